// ===== sv/ils_pkg.sv =====
package ils_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int FILL_BITS = $clog2(DEPTH + 1);

    localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(DEPTH);
    localparam logic [6:0]           LVL_FULL  = 7'(DEPTH);

    typedef enum logic [2:0] {
        FN_PUSH  = 3'd0,
        FN_POP   = 3'd1,
        FN_TOP   = 3'd2,
        FN_READ  = 3'd3,
        FN_DUMP  = 3'd4,
        FN_WRITE = 3'd5
    } func_e;

    typedef enum logic [2:0] {
        STS_DONE  = 3'd0,
        STS_FULL  = 3'd1,
        STS_EMPTY = 3'd2,
        STS_LOW   = 3'd3,
        STS_HIGH  = 3'd4
    } status_e;

    typedef enum logic [1:0] {
        K_DIRECT,
        K_READ,
        K_DUMP
    } kind_e;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DUMP
    } state_e;

    typedef struct packed {
        logic [2:0]         func;
        logic [6:0]         position;
        logic signed [31:0] word_in;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] word_out;
        logic               last;
        logic [6:0]         fill_level;
        logic               is_empty_flag;
        logic               is_full_flag;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic load_now;
        logic load_rd;
        logic rd_in;
        logic dump_start;
        logic dump_step;
        logic last;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic  in_valid;
        logic  out_free;
        kind_e kind;
        logic  dump_last;
    } sts_t;

    function automatic logic [WORD_BITS-1:0] word_to_store(logic [31:0] w);
        logic [63:0] t;
        t = '0;
        t[31:0] = w;
        return t[WORD_BITS-1:0];
    endfunction

    function automatic logic [31:0] word_to_out(logic [WORD_BITS-1:0] w);
        logic [63:0] t;
        t = '0;
        t[WORD_BITS-1:0] = w;
        return t[31:0];
    endfunction

    function automatic logic [6:0] fill_to_lvl(logic [FILL_BITS-1:0] f);
        logic [6:0] t;
        t = '0;
        t[FILL_BITS-1:0] = f;
        return t;
    endfunction

endpackage

// ===== sv/ils_ctrl.sv =====
module ils_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  ils_pkg::sts_t sts,
    output ils_pkg::cmd_t cmd,
    output logic          cmd_stall
);

    ils_pkg::state_e state_reg;
    ils_pkg::state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ils_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ils_pkg::S_IDLE:
            begin
                if (sts.in_valid && sts.out_free)
                begin
                    unique case (sts.kind)
                        ils_pkg::K_READ:   state_next = ils_pkg::S_READ;
                        ils_pkg::K_DUMP:   state_next = ils_pkg::S_DUMP;
                        default:           state_next = ils_pkg::S_IDLE;
                    endcase
                end
            end
            ils_pkg::S_READ:
            begin
                if (sts.out_free)
                begin
                    state_next = ils_pkg::S_IDLE;
                end
            end
            ils_pkg::S_DUMP:
            begin
                if (sts.out_free && sts.dump_last)
                begin
                    state_next = ils_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ils_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd_stall = 1'b1;
        unique case (state_reg)
            ils_pkg::S_IDLE:
            begin
                cmd_stall = !sts.out_free;
                if (sts.in_valid && sts.out_free)
                begin
                    cmd.accept     = 1'b1;
                    cmd.load_now   = (sts.kind == ils_pkg::K_DIRECT);
                    cmd.rd_in      = (sts.kind != ils_pkg::K_DIRECT);
                    cmd.dump_start = (sts.kind == ils_pkg::K_DUMP);
                end
            end
            ils_pkg::S_READ:
            begin
                if (sts.out_free)
                begin
                    cmd.load_rd = 1'b1;
                    cmd.last    = 1'b1;
                end
            end
            ils_pkg::S_DUMP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_rd   = 1'b1;
                    cmd.last      = sts.dump_last;
                    cmd.dump_step = !sts.dump_last;
                end
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== sv/ils_dp.sv =====
module ils_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  ils_pkg::in_item_t cmd_item,
    input  logic              rsp_stall,
    output logic              rsp_valid,
    output ils_pkg::out_item_t rsp_item,
    input  ils_pkg::cmd_t     cmd,
    output ils_pkg::sts_t     sts
);

    logic [ils_pkg::WORD_BITS-1:0] mem [ils_pkg::DEPTH];

    logic [ils_pkg::FILL_BITS-1:0] fill_reg;
    logic [ils_pkg::FILL_BITS-1:0] fill_next;
    logic [ils_pkg::FILL_BITS-1:0] idx_reg;
    logic [ils_pkg::FILL_BITS-1:0] fill_m1;
    logic [ils_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                          out_valid_reg;
    ils_pkg::out_item_t            out_reg;

    ils_pkg::kind_e                kind;
    ils_pkg::status_e              status;
    logic                          we;
    logic [ils_pkg::ADDR_BITS-1:0] waddr;
    logic [ils_pkg::ADDR_BITS-1:0] raddr_dec;
    logic [ils_pkg::ADDR_BITS-1:0] raddr;
    logic [6:0]                    pos_m1;
    logic [6:0]                    fill_lvl;
    logic                          stack_empty;
    logic                          stack_full;

    assign fill_m1     = fill_reg - ils_pkg::FILL_BITS'(1);
    assign pos_m1      = cmd_item.position - 7'd1;
    assign fill_lvl    = ils_pkg::fill_to_lvl(fill_reg);
    assign stack_empty = (fill_reg == '0);
    assign stack_full  = (fill_reg == ils_pkg::FILL_FULL);

    always_comb
    begin
        kind      = ils_pkg::K_DIRECT;
        status    = ils_pkg::STS_DONE;
        we        = 1'b0;
        waddr     = fill_reg[ils_pkg::ADDR_BITS-1:0];
        raddr_dec = '0;
        fill_next = fill_reg;
        priority if (cmd_item.func == ils_pkg::FN_PUSH)
        begin
            if (stack_full)
            begin
                status = ils_pkg::STS_FULL;
            end
            else
            begin
                we        = 1'b1;
                fill_next = fill_reg + ils_pkg::FILL_BITS'(1);
            end
        end
        else if (cmd_item.func > ils_pkg::FN_WRITE)
        begin
            status = ils_pkg::STS_DONE;
        end
        else if (stack_empty)
        begin
            status = ils_pkg::STS_EMPTY;
        end
        else
        begin
            unique case (cmd_item.func)
                ils_pkg::FN_POP:
                begin
                    fill_next = fill_m1;
                end
                ils_pkg::FN_TOP:
                begin
                    kind      = ils_pkg::K_READ;
                    raddr_dec = fill_m1[ils_pkg::ADDR_BITS-1:0];
                end
                ils_pkg::FN_DUMP:
                begin
                    kind = ils_pkg::K_DUMP;
                end
                ils_pkg::FN_READ, ils_pkg::FN_WRITE:
                begin
                    priority if (cmd_item.position == 7'd0)
                    begin
                        status = ils_pkg::STS_LOW;
                    end
                    else if (cmd_item.position > fill_lvl)
                    begin
                        status = ils_pkg::STS_HIGH;
                    end
                    else if (cmd_item.func == ils_pkg::FN_READ)
                    begin
                        kind      = ils_pkg::K_READ;
                        raddr_dec = pos_m1[ils_pkg::ADDR_BITS-1:0];
                    end
                    else
                    begin
                        we    = 1'b1;
                        waddr = pos_m1[ils_pkg::ADDR_BITS-1:0];
                    end
                end
                default:
                begin
                    status = ils_pkg::STS_DONE;
                end
            endcase
        end
    end

    assign raddr = cmd.dump_step ? idx_reg[ils_pkg::ADDR_BITS-1:0] : raddr_dec;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && we)
        begin
            mem[waddr] <= ils_pkg::word_to_store(cmd_item.word_in);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_in || cmd.dump_step)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                fill_reg <= fill_next;
            end
            // idx_reg counts entries already fetched during a dump
            if (cmd.dump_start)
            begin
                idx_reg <= ils_pkg::FILL_BITS'(1);
            end
            else if (cmd.dump_step)
            begin
                idx_reg <= idx_reg + ils_pkg::FILL_BITS'(1);
            end
            if (cmd.load_now || cmd.load_rd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_now)
        begin
            out_reg.status        <= status;
            out_reg.word_out      <= '0;
            out_reg.last          <= 1'b1;
            out_reg.fill_level    <= ils_pkg::fill_to_lvl(fill_next);
            out_reg.is_empty_flag <= (fill_next == '0);
            out_reg.is_full_flag  <= (fill_next == ils_pkg::FILL_FULL);
        end
        else if (cmd.load_rd)
        begin
            out_reg.status        <= ils_pkg::STS_DONE;
            out_reg.word_out      <= ils_pkg::word_to_out(rd_data_reg);
            out_reg.last          <= cmd.last;
            out_reg.fill_level    <= fill_lvl;
            out_reg.is_empty_flag <= stack_empty;
            out_reg.is_full_flag  <= stack_full;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

    assign sts.in_valid  = cmd_valid;
    assign sts.out_free  = !out_valid_reg || !rsp_stall;
    assign sts.kind      = kind;
    assign sts.dump_last = (idx_reg == fill_reg);

endmodule

// ===== sv/indexed_lifo_stack_unit.sv =====
// Indexed LIFO stack of up to 64 signed 32-bit words, positions 1 (bottom)
// to the fill count (top). Push, pop, write position and every refused
// operation can be issued back to back while the output is not stalled.
// Read top and read position also pass through the read state: the entry
// memory has one registered read port, so the result is formed from the
// registered read data. A dump streams one entry per cycle, bottom first,
// with last set on the top entry. No command is taken while a read or
// dump is in progress. Output stall holds the result register and pauses
// a dump. Entries need no clearing after reset; only the fill count, dump
// index, output valid flag and controller state are reset.
module indexed_lifo_stack_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  ils_pkg::in_item_t  cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ils_pkg::out_item_t rsp_item
);

    ils_pkg::cmd_t cmd;
    ils_pkg::sts_t sts;

    ils_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sts       (sts),
        .cmd       (cmd),
        .cmd_stall (cmd_stall)
    );

    ils_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_item  (cmd_item),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_item  (rsp_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== sv/ils_chk.sv =====
module ils_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input ils_pkg::in_item_t  cmd_item,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input ils_pkg::out_item_t rsp_item
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("stalled transfer changed");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.is_empty_flag == (rsp_item.fill_level == 7'd0)))
        else $error("empty flag disagrees with fill level");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.is_full_flag == (rsp_item.fill_level == ils_pkg::LVL_FULL)))
        else $error("full flag disagrees with fill level");

    a_dump_mid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_item.last |->
            rsp_item.status == ils_pkg::STS_DONE && !rsp_item.is_empty_flag)
        else $error("non-final transfer outside a dump");

endmodule

bind indexed_lifo_stack_unit ils_chk u_chk (.*);
